[rtl/prime_field_arithmetic_unit_top_defines.svh]
// assertion macros for the prime field unit
`ifndef PRIME_FIELD_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define PRIME_FIELD_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PFA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pfa_pkg.sv]
package pfa_pkg;

  localparam int unsigned MOD_WIDTH_DEF = 31;
  localparam logic [61:0] MODULUS_RESET = 62'd2147483647;

  // operation codes
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_POW_CHECK,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_FINAL_MUL,
    ST_MUL_WAIT,
    ST_OUT
  } state_t;

  // datapath operations run by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RED_A_START,
    DP_RED_B_START,
    DP_ADD,
    DP_SUB,
    DP_ZERO_ERR,
    DP_POW_INIT,
    DP_MUL_AB,
    DP_MUL_ACC_BASE,
    DP_MUL_BASE_BASE,
    DP_MUL_A_ACC,
    DP_SHIFT_EXP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_busy;
    logic b_zero;
    logic exp_zero;
    logic exp_lsb;
  } dp_stat_t;

endpackage

[rtl/prime_field_arithmetic_unit_top.sv]
// GF(p) arithmetic unit: add, subtract, multiply and divide modulo the prime held in
// cfg_modulus. One transaction at a time; both operands are reduced by a bit-serial
// remainder pass, multiply uses the same shared shift-and-add unit, and divide raises
// b to p-2 by square-and-multiply and multiplies a by the result. The shared serial
// unit sets the rate.
// A zero divisor gives result 0 with out_divide_error set.
`include "prime_field_arithmetic_unit_top_defines.svh"

module prime_field_arithmetic_unit_top #(
  parameter int unsigned MOD_WIDTH = pfa_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [MOD_WIDTH-1:0] cfg_modulus,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [MOD_WIDTH-1:0] in_operand_a,
  input  logic [MOD_WIDTH-1:0] in_operand_b,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MOD_WIDTH-1:0] out_result,
  output logic                 out_divide_error
);

  logic [MOD_WIDTH-1:0] modulus_r;
  pfa_pkg::dp_cmd_t     cmd;
  pfa_pkg::dp_stat_t    stat;
  pfa_pkg::state_t      state;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= pfa_pkg::MODULUS_RESET[MOD_WIDTH-1:0];
    end else if (cfg_we) begin
      modulus_r <= cfg_modulus;
    end
  end

  pfa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd),
    .state_q     (state)
  );

  pfa_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .p_in  (modulus_r),
    .a_in  (in_operand_a),
    .b_in  (in_operand_b),
    .stat  (stat),
    .res_q (out_result),
    .err_q (out_divide_error)
  );

  // checks
  `PFA_ASSERT_IMPL(a_out_idle, out_valid, state == pfa_pkg::ST_OUT, "result outside output state")
  `PFA_ASSERT_IMPL(a_stall_busy, state != pfa_pkg::ST_IDLE, in_stall, "input taken while busy")
  `PFA_ASSERT_NEXT(a_out_done, out_valid && !out_stall, state == pfa_pkg::ST_IDLE, "no return to idle")

endmodule

[rtl/pfa_datapath.sv]
module pfa_datapath #(
  parameter int unsigned MOD_WIDTH = pfa_pkg::MOD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfa_pkg::dp_cmd_t     cmd,
  input  logic [MOD_WIDTH-1:0] p_in,
  input  logic [MOD_WIDTH-1:0] a_in,
  input  logic [MOD_WIDTH-1:0] b_in,
  output pfa_pkg::dp_stat_t    stat,
  output logic [MOD_WIDTH-1:0] res_q,
  output logic                 err_q
);

  localparam int unsigned CW = $clog2(MOD_WIDTH + 1);
  localparam int unsigned CNT = MOD_WIDTH;

  logic [MOD_WIDTH-1:0] p_r, a_r, b_r, acc_r, base_r, exp_r, res_r;
  logic [MOD_WIDTH-1:0] p_nxt, a_nxt, b_nxt, acc_nxt, base_nxt, exp_nxt, res_nxt;
  logic                 err_r, err_nxt;

  // shared serial unit: mode 0 reduce, mode 1 multiply
  logic                 busy_r, busy_nxt;
  logic                 mode_r, mode_nxt;
  logic [1:0]           dst_r, dst_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [MOD_WIDTH-1:0] ux_r, ux_nxt, uy_r, uy_nxt, uacc_r, uacc_nxt;

  localparam logic [1:0] DST_A = 2'd0;
  localparam logic [1:0] DST_B = 2'd1;
  localparam logic [1:0] DST_ACC = 2'd2;
  localparam logic [1:0] DST_BASE = 2'd3;

  logic [MOD_WIDTH:0]   dbl, dbl_red, addv;
  logic [MOD_WIDTH:0]   sum_ab;
  logic [MOD_WIDTH-1:0] step1, step2;
  logic                 ybit;
  logic                 done;

  // plain sum of the reduced operands
  assign sum_ab = {1'b0, a_r} + {1'b0, b_r};

  // one bit of the shift and add / shift and subtract loop
  always_comb begin
    ybit  = uy_r[MOD_WIDTH-1];
    dbl   = {uacc_r, 1'b0};
    if (mode_r) begin
      dbl_red = (dbl >= {1'b0, p_r}) ? dbl - {1'b0, p_r} : dbl;
      step1 = dbl_red[MOD_WIDTH-1:0];
      addv  = {1'b0, step1} + {1'b0, ux_r};
      step2 = ybit ? ((addv >= {1'b0, p_r}) ? MOD_WIDTH'(addv - {1'b0, p_r})
                                            : addv[MOD_WIDTH-1:0]) : step1;
    end else begin
      // restoring remainder, bringing in one operand bit
      dbl_red = {uacc_r, ybit};
      step1 = '0;
      addv  = '0;
      step2 = (dbl_red >= {1'b0, p_r}) ? MOD_WIDTH'(dbl_red - {1'b0, p_r})
                                       : dbl_red[MOD_WIDTH-1:0];
    end
    done = busy_r && (cnt_r == CW'(1));
  end

  // registers of the datapath
  always_comb begin
    p_nxt = p_r; a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; base_nxt = base_r;
    exp_nxt = exp_r; res_nxt = res_r; err_nxt = err_r;
    busy_nxt = busy_r; mode_nxt = mode_r; dst_nxt = dst_r; cnt_nxt = cnt_r;
    ux_nxt = ux_r; uy_nxt = uy_r; uacc_nxt = uacc_r;

    if (busy_r) begin
      uacc_nxt = step2;
      uy_nxt   = {uy_r[MOD_WIDTH-2:0], 1'b0};
      cnt_nxt  = cnt_r - CW'(1);
      if (done) begin
        busy_nxt = 1'b0;
        unique case (dst_r)
          DST_A:    a_nxt = step2;
          DST_B:    b_nxt = step2;
          DST_ACC:  acc_nxt = step2;
          DST_BASE: base_nxt = step2;
          default:  acc_nxt = step2;
        endcase
      end
    end

    unique case (cmd.op)
      pfa_pkg::DP_LOAD: begin
        p_nxt = (p_in < MOD_WIDTH'(2)) ? MOD_WIDTH'(1) : p_in;
        a_nxt = a_in; b_nxt = b_in; err_nxt = 1'b0;
      end
      pfa_pkg::DP_RED_A_START: begin
        busy_nxt = 1'b1; mode_nxt = 1'b0; dst_nxt = DST_A; cnt_nxt = CW'(CNT);
        uy_nxt = a_r; uacc_nxt = '0; ux_nxt = '0;
      end
      pfa_pkg::DP_RED_B_START: begin
        busy_nxt = 1'b1; mode_nxt = 1'b0; dst_nxt = DST_B; cnt_nxt = CW'(CNT);
        uy_nxt = b_r; uacc_nxt = '0; ux_nxt = '0;
      end
      pfa_pkg::DP_ADD: begin
        res_nxt = (sum_ab >= {1'b0, p_r}) ? MOD_WIDTH'(sum_ab - {1'b0, p_r})
                                          : sum_ab[MOD_WIDTH-1:0];
      end
      pfa_pkg::DP_SUB: begin
        res_nxt = (a_r >= b_r) ? a_r - b_r : MOD_WIDTH'(({1'b0, a_r} + {1'b0, p_r})
                                                        - {1'b0, b_r});
      end
      pfa_pkg::DP_ZERO_ERR: begin
        res_nxt = '0; err_nxt = 1'b1;
      end
      pfa_pkg::DP_POW_INIT: begin
        acc_nxt = (p_r == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
        base_nxt = b_r;
        exp_nxt = p_r - MOD_WIDTH'(2);
      end
      pfa_pkg::DP_MUL_AB: begin
        busy_nxt = 1'b1; mode_nxt = 1'b1; dst_nxt = DST_ACC; cnt_nxt = CW'(CNT);
        ux_nxt = a_r; uy_nxt = b_r; uacc_nxt = '0;
      end
      pfa_pkg::DP_MUL_ACC_BASE: begin
        busy_nxt = 1'b1; mode_nxt = 1'b1; dst_nxt = DST_ACC; cnt_nxt = CW'(CNT);
        ux_nxt = acc_r; uy_nxt = base_r; uacc_nxt = '0;
      end
      pfa_pkg::DP_MUL_BASE_BASE: begin
        busy_nxt = 1'b1; mode_nxt = 1'b1; dst_nxt = DST_BASE; cnt_nxt = CW'(CNT);
        ux_nxt = base_r; uy_nxt = base_r; uacc_nxt = '0;
        exp_nxt = exp_r >> 1;
      end
      pfa_pkg::DP_MUL_A_ACC: begin
        busy_nxt = 1'b1; mode_nxt = 1'b1; dst_nxt = DST_ACC; cnt_nxt = CW'(CNT);
        ux_nxt = a_r; uy_nxt = acc_r; uacc_nxt = '0;
      end
      pfa_pkg::DP_SHIFT_EXP: begin
        res_nxt = acc_r; err_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      err_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      err_r  <= err_nxt;
      cnt_r  <= cnt_nxt;
    end
    p_r <= p_nxt; a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt; base_r <= base_nxt;
    exp_r <= exp_nxt; res_r <= res_nxt; mode_r <= mode_nxt; dst_r <= dst_nxt;
    ux_r <= ux_nxt; uy_r <= uy_nxt; uacc_r <= uacc_nxt;
  end

  assign stat.unit_busy = busy_r;
  assign stat.b_zero    = (b_r == '0);
  assign stat.exp_zero  = (exp_r == '0);
  assign stat.exp_lsb   = exp_r[0];
  assign res_q = res_r;
  assign err_q = err_r;

endmodule

[rtl/pfa_ctrl.sv]
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_req_type,
  output logic              out_valid,
  input  logic              out_stall,
  input  pfa_pkg::dp_stat_t stat,
  output pfa_pkg::dp_cmd_t  cmd,
  output pfa_pkg::state_t   state_q
);

  pfa_pkg::state_t state_r, state_nxt;
  pfa_pkg::op_t    op_r, op_nxt;
  logic            accept;

  assign accept = in_valid && (state_r == pfa_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    unique case (state_r)
      pfa_pkg::ST_IDLE: if (accept) begin
        state_nxt = pfa_pkg::ST_RED_A;
        op_nxt = pfa_pkg::op_t'(in_req_type);
      end
      pfa_pkg::ST_RED_A: state_nxt = pfa_pkg::ST_RED_B;
      pfa_pkg::ST_RED_B: if (!stat.unit_busy) state_nxt = pfa_pkg::ST_MUL_WAIT;
      pfa_pkg::ST_MUL_WAIT: if (!stat.unit_busy) state_nxt = pfa_pkg::ST_DISPATCH;
      pfa_pkg::ST_DISPATCH: begin
        unique case (op_r)
          pfa_pkg::OP_ADD, pfa_pkg::OP_SUB: state_nxt = pfa_pkg::ST_OUT;
          pfa_pkg::OP_MUL: state_nxt = pfa_pkg::ST_FINAL_MUL;
          pfa_pkg::OP_DIV: begin
            state_nxt = stat.b_zero ? pfa_pkg::ST_OUT : pfa_pkg::ST_POW_CHECK;
            // zero divisor result is final, no copy from the accumulator
            if (stat.b_zero) op_nxt = pfa_pkg::OP_ADD;
          end
          default: state_nxt = pfa_pkg::ST_OUT;
        endcase
      end
      pfa_pkg::ST_POW_CHECK: if (!stat.unit_busy) begin
        priority if (stat.exp_zero) state_nxt = pfa_pkg::ST_FINAL_MUL;
        else if (stat.exp_lsb) state_nxt = pfa_pkg::ST_POW_MUL;
        else state_nxt = pfa_pkg::ST_POW_SQR;
      end
      pfa_pkg::ST_POW_MUL: if (!stat.unit_busy) state_nxt = pfa_pkg::ST_POW_SQR;
      pfa_pkg::ST_POW_SQR: state_nxt = pfa_pkg::ST_POW_CHECK;
      pfa_pkg::ST_FINAL_MUL: state_nxt = pfa_pkg::ST_OUT;
      pfa_pkg::ST_OUT: begin
        if (!stat.unit_busy && op_r != pfa_pkg::OP_ADD && op_r != pfa_pkg::OP_SUB)
          op_nxt = pfa_pkg::OP_ADD;
        if (out_valid && !out_stall) state_nxt = pfa_pkg::ST_IDLE;
      end
      default: state_nxt = pfa_pkg::ST_IDLE;
    endcase
  end

  // commands and handshake
  always_comb begin
    cmd.op    = pfa_pkg::DP_NOP;
    in_stall  = (state_r != pfa_pkg::ST_IDLE);
    out_valid = 1'b0;
    unique case (state_r)
      pfa_pkg::ST_IDLE: if (accept) cmd.op = pfa_pkg::DP_LOAD;
      pfa_pkg::ST_RED_A: cmd.op = pfa_pkg::DP_RED_A_START;
      pfa_pkg::ST_RED_B: if (!stat.unit_busy) cmd.op = pfa_pkg::DP_RED_B_START;
      pfa_pkg::ST_DISPATCH: begin
        unique case (op_r)
          pfa_pkg::OP_ADD: cmd.op = pfa_pkg::DP_ADD;
          pfa_pkg::OP_SUB: cmd.op = pfa_pkg::DP_SUB;
          pfa_pkg::OP_MUL: cmd.op = pfa_pkg::DP_MUL_AB;
          pfa_pkg::OP_DIV: cmd.op = stat.b_zero ? pfa_pkg::DP_ZERO_ERR
                                                : pfa_pkg::DP_POW_INIT;
          default: cmd.op = pfa_pkg::DP_NOP;
        endcase
      end
      pfa_pkg::ST_POW_CHECK: if (!stat.unit_busy && !stat.exp_zero) begin
        if (stat.exp_lsb) cmd.op = pfa_pkg::DP_MUL_ACC_BASE;
      end else if (!stat.unit_busy && stat.exp_zero) begin
        cmd.op = pfa_pkg::DP_MUL_A_ACC;
      end
      pfa_pkg::ST_POW_SQR: cmd.op = pfa_pkg::DP_MUL_BASE_BASE;
      pfa_pkg::ST_OUT: begin
        if (!stat.unit_busy && op_r != pfa_pkg::OP_ADD && op_r != pfa_pkg::OP_SUB)
          cmd.op = pfa_pkg::DP_SHIFT_EXP;
        out_valid = !stat.unit_busy && (op_r == pfa_pkg::OP_ADD || op_r == pfa_pkg::OP_SUB);
      end
      default: cmd.op = pfa_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::ST_IDLE;
      op_r    <= pfa_pkg::OP_ADD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  assign state_q = state_r;

endmodule
